// ===== rtl/core/wsa_pkg.sv =====
// Shared types and constants for the weighted slot allocator.
// Depends on nothing; every core file refers to it by scoped names.
`default_nettype none

package wsa_pkg;

	// Number of priority groups and the width of a group index
	localparam int GROUPS  = 4;
	localparam int GROUP_W = 2;

	// Field widths fixed by the register map and input format
	localparam int WEIGHT_W  = 8;
	localparam int TOTAL_W   = 10;   // sum of four 8-bit weights
	localparam int RAND_W    = 16;
	localparam int CFG_IDX_W = 8;

	// Weight register reset values, group 0 in the lowest byte
	localparam logic [GROUPS-1:0][WEIGHT_W-1:0] WEIGHT_RESET = {8'd0, 8'd9, 8'd3, 8'd1};

	// Control from the top level into the sequencer
	typedef struct packed {
		logic start;   // input transaction accepted this cycle
		logic take;    // finished result moved to the output register
	} seq_ctrl_t;

	// Status from the sequencer back to the top level
	typedef struct packed {
		logic idle;    // ready for a new item
		logic done;    // grants are final and waiting
	} seq_stat_t;

	// Handshake between the sequencer and the shared divider
	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/wsa_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Shared by the allocator for budget/total and random mod total.
// Uses wsa_pkg for its handshake structs.
`default_nettype none

module wsa_div #(
	parameter int DW = 16,   // dividend width
	parameter int VW = 10    // divisor width
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wsa_pkg::div_ctrl_t   ctrl,
	input  wire  [DW-1:0]        dividend,
	input  wire  [VW-1:0]        divisor,
	output wsa_pkg::div_stat_t   stat,
	output logic [DW-1:0]        quotient,
	output logic [VW-1:0]        remainder
);

	localparam int CW = $clog2(DW + 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;

	logic [VW:0]   trial;
	logic          fits;
	logic [VW:0]   diff;

	// Shift the next dividend bit into the partial remainder and try a subtract
	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		fits  = trial >= {1'b0, divisor};
		diff  = trial - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CW'(DW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Datapath: quotient bits shift in as dividend bits shift out
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
		end
	end

	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== rtl/core/wsa_seq.sv =====
// Allocation sequencer: equal-share rounds and round-robin remainder,
// walking the four groups in turn around a shared divider.
// Depends on wsa_pkg and wsa_div.
`default_nettype none

module wsa_seq #(
	parameter int COUNT_BITS = 10
) (
	input  wire                                                  clk,
	input  wire                                                  arst_n,
	input  wsa_pkg::seq_ctrl_t                                   ctrl,
	input  wire  [wsa_pkg::GROUPS-1:0][wsa_pkg::WEIGHT_W-1:0]    weight,
	input  wire  [COUNT_BITS-1:0]                                budget,
	input  wire  [wsa_pkg::GROUPS-1:0][COUNT_BITS-1:0]           size,
	input  wire  [wsa_pkg::RAND_W-1:0]                           rnd,
	output wsa_pkg::seq_stat_t                                   stat,
	output logic [wsa_pkg::GROUPS-1:0][COUNT_BITS-1:0]           grant
);

	localparam int CB = COUNT_BITS;
	localparam int WW = wsa_pkg::WEIGHT_W;
	localparam int TW = wsa_pkg::TOTAL_W;
	localparam int GW = wsa_pkg::GROUP_W;
	localparam int DW = (CB > wsa_pkg::RAND_W) ? CB : wsa_pkg::RAND_W;
	localparam int LW = (CB > TW) ? CB : TW;
	localparam int MW = (CB > WW) ? CB : WW;
	localparam int PW = CB + WW;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVQ,
		ST_MUL,
		ST_APPLY,
		ST_DIVR,
		ST_FIND,
		ST_RR,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [CB-1:0]                      left_q;
	logic [wsa_pkg::GROUPS-1:0][CB-1:0] size_q;
	logic [wsa_pkg::GROUPS-1:0][CB-1:0] grant_q;
	logic [wsa_pkg::RAND_W-1:0]         rnd_q;
	logic [TW-1:0]                      total_q;
	logic [CB-1:0]                      base_q;
	logic [PW-1:0]                      product_q;
	logic [TW-1:0]                      start_q;
	logic [GW-1:0]                      g_q;

	// Divider hookup
	wsa_pkg::div_ctrl_t div_ctrl;
	wsa_pkg::div_stat_t div_stat;
	logic [DW-1:0]      div_dividend;
	logic [DW-1:0]      div_quo;
	logic [TW-1:0]      div_rem;

	// Per-group step helpers
	logic [WW-1:0] wgt;
	logic [CB-1:0] sz;
	logic [CB-1:0] gr;
	logic          active;
	logic [CB-1:0] need;
	logic [CB-1:0] share_u;
	logic [MW-1:0] span;
	logic [MW-1:0] rr_min;
	logic [CB-1:0] rr_u;
	logic [TW-1:0] total_sum;
	logic          can_share;
	logic          has_rest;
	logic          last_g;

	always_comb begin
		wgt     = weight[g_q];
		sz      = size_q[g_q];
		gr      = grant_q[g_q];
		active  = (wgt != '0) && (gr < sz);
		need    = sz - gr;
		share_u = (product_q < PW'(need)) ? product_q[CB-1:0] : need;
		// start is below the weight of the first remainder group, zero afterwards
		span    = MW'(wgt - start_q[WW-1:0]);
		rr_min  = (MW'(left_q) < MW'(need)) ? MW'(left_q) : MW'(need);
		rr_min  = (span < rr_min) ? span : rr_min;
		rr_u    = rr_min[CB-1:0];
		last_g  = g_q == GW'(wsa_pkg::GROUPS - 1);
	end

	// Total weight of groups that have members
	always_comb begin
		total_sum = '0;
		for (int g = 0; g < wsa_pkg::GROUPS; g++) begin
			if (size[g] != '0) begin
				total_sum = total_sum + TW'(weight[g]);
			end
		end
	end

	always_comb begin
		can_share = (total_q != '0) && (LW'(left_q) >= LW'(total_q));
		has_rest  = (total_q != '0) && (left_q != '0);
	end

	// Divider starts from the round check: budget/total or random mod total
	always_comb begin
		div_ctrl.start = (state_q == ST_CHECK) && (can_share || has_rest);
		div_dividend   = can_share ? DW'(left_q) : DW'(rnd_q);
	end

	wsa_div #(
		.DW(DW),
		.VW(TW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (div_ctrl),
		.dividend  (div_dividend),
		.divisor   (total_q),
		.stat      (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctrl.start) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (can_share) begin
						state_q <= ST_DIVQ;
					end else if (has_rest) begin
						state_q <= ST_DIVR;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DIVQ: begin
					if (div_stat.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					state_q <= last_g ? ST_CHECK : ST_MUL;
				end
				ST_DIVR: begin
					if (div_stat.done) begin
						state_q <= ST_FIND;
					end
				end
				ST_FIND: begin
					if (active && (start_q < TW'(wgt))) begin
						state_q <= ST_RR;
					end
				end
				ST_RR: begin
					if (!has_rest) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (ctrl.take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				left_q  <= budget;
				size_q  <= size;
				rnd_q   <= rnd;
				total_q <= total_sum;
				grant_q <= '0;
				g_q     <= '0;
			end
			ST_DIVQ: begin
				base_q <= div_quo[CB-1:0];
				g_q    <= '0;
			end
			ST_MUL: begin
				product_q <= PW'(base_q) * PW'(wgt);
			end
			ST_APPLY: begin
				// Equal share for one group, capped by what it still needs
				if (active) begin
					grant_q[g_q] <= gr + share_u;
					left_q       <= left_q - share_u;
					if (share_u == need) begin
						total_q <= total_q - TW'(wgt);
					end
				end
				g_q <= g_q + 1'b1;
			end
			ST_DIVR: begin
				start_q <= div_rem;
				g_q     <= '0;
			end
			ST_FIND: begin
				// Walk the weighted positions to the group holding the start
				if (active) begin
					if (start_q >= TW'(wgt)) begin
						start_q <= start_q - TW'(wgt);
						g_q     <= g_q + 1'b1;
					end
				end else begin
					g_q <= g_q + 1'b1;
				end
			end
			ST_RR: begin
				// Round-robin remainder, one group visit per cycle
				if (has_rest) begin
					if (active) begin
						grant_q[g_q] <= gr + rr_u;
						left_q       <= left_q - rr_u;
						start_q      <= '0;
						if (rr_u == need) begin
							total_q <= total_q - TW'(wgt);
						end
					end
					g_q <= g_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.idle = state_q == ST_IDLE;
	assign stat.done = state_q == ST_DONE;
	assign grant     = grant_q;

endmodule

`default_nettype wire

// ===== rtl/core/weighted_slot_allocator_core.sv =====
// Weighted slot allocator: splits a slot budget over four groups by
// configured weights, one item at a time. Item i/o is a stream pair with
// an output register, so a new item is taken while a result waits.
// For COUNT_BITS up to 16 the shared divider runs 16 steps per division.
// With zero budget or zero total weight an item goes from the check
// straight to done. Each equal-share round is a check, the division and
// a multiply and an update for each group. There are at most four
// rounds, because every round but the last fills a group. A remainder
// adds the check and the modulo division, a walk over up to four groups
// to find the start group, the round-robin group visits and a finish
// step. When only a weight-one group is still open, that is four visits
// per slot. A result stalled on m_tready holds the next item in its done
// state. Weight registers are written through the cfg channel, which is
// always ready.
// Depends on wsa_pkg and wsa_seq.
`default_nettype none

module weighted_slot_allocator_core #(
	parameter int COUNT_BITS = 10
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// Weight register writes
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [wsa_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [wsa_pkg::WEIGHT_W-1:0]         cfg_data,
	// Input items
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	// s_tdata, low bit up: slot_budget, size_group0, size_group1,
	// size_group2, size_group3, random_word, zero pad
	input  wire  [((5*COUNT_BITS + wsa_pkg::RAND_W + 7) / 8) * 8 - 1:0] s_tdata,
	// Results
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	// m_tdata, low bit up: grant_group0, grant_group1, grant_group2,
	// grant_group3, zero pad
	output logic [((4*COUNT_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int CB = COUNT_BITS;
	localparam int OW = ((4*COUNT_BITS + 7) / 8) * 8;
	localparam int NG = wsa_pkg::GROUPS;

	logic [NG-1:0][wsa_pkg::WEIGHT_W-1:0] weight_q;

	logic [CB-1:0]                  budget;
	logic [NG-1:0][CB-1:0]          size;
	logic [wsa_pkg::RAND_W-1:0]     rnd;
	logic [NG-1:0][CB-1:0]          grant;
	logic [OW-1:0]                  out_pack;

	wsa_pkg::seq_ctrl_t seq_ctrl;
	wsa_pkg::seq_stat_t seq_stat;

	logic          m_tvalid_q;
	logic [OW-1:0] m_tdata_q;

	// Weight registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= wsa_pkg::WEIGHT_RESET;
		end else if (cfg_valid && (cfg_index < wsa_pkg::CFG_IDX_W'(NG))) begin
			weight_q[cfg_index[wsa_pkg::GROUP_W-1:0]] <= cfg_data;
		end
	end

	// Unpack the input transaction
	always_comb begin
		budget = s_tdata[CB-1:0];
		for (int g = 0; g < NG; g++) begin
			size[g] = s_tdata[CB*(g+1) +: CB];
		end
		rnd = s_tdata[CB*(NG+1) +: wsa_pkg::RAND_W];
	end

	assign s_tready       = seq_stat.idle;
	assign seq_ctrl.start = s_tvalid && seq_stat.idle;
	assign seq_ctrl.take  = seq_stat.done && (!m_tvalid_q || m_tready);

	wsa_seq #(
		.COUNT_BITS(CB)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (seq_ctrl),
		.weight (weight_q),
		.budget (budget),
		.size   (size),
		.rnd    (rnd),
		.stat   (seq_stat),
		.grant  (grant)
	);

	// Pack grants for the output register
	always_comb begin
		out_pack = '0;
		for (int g = 0; g < NG; g++) begin
			out_pack[g*CB +: CB] = grant[g];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (seq_ctrl.take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_ctrl.take) begin
			m_tdata_q <= out_pack;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire
